// ===== hdl/dqpt_pkg.sv =====
package dqpt_pkg;

  localparam int DATA_W    = 32;
  localparam int CFG_IDX_W = 3;

  // position of the scalar part in a quaternion
  localparam int W_IDX = 3;

  typedef logic [DATA_W-1:0] word_t;

  typedef struct packed {
    word_t [3:0] r;
    word_t [3:0] d;
  } pose_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REAL_X,
    REG_REAL_Y,
    REG_REAL_Z,
    REG_REAL_W,
    REG_DUAL_X,
    REG_DUAL_Y,
    REG_DUAL_Z,
    REG_DUAL_W
  } cfg_reg_t;

endpackage

// ===== hdl/dqpt_cfg_regs.sv =====
module dqpt_cfg_regs #(
  parameter int FRAC_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [dqpt_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [dqpt_pkg::DATA_W-1:0]      wr_data,
  output dqpt_pkg::pose_t                  pose
);

  localparam int DW = dqpt_pkg::DATA_W;
  localparam logic [DW-1:0] ONE = DW'(1) << FRAC_BITS;

  // identity pose out of reset
  always_ff @(posedge clk) begin
    if (rst) begin
      pose.r[0]               <= '0;
      pose.r[1]               <= '0;
      pose.r[2]               <= '0;
      pose.r[dqpt_pkg::W_IDX] <= ONE;
      pose.d                  <= '0;
    end else if (wr_en) begin
      unique case (dqpt_pkg::cfg_reg_t'(wr_index))
        dqpt_pkg::REG_REAL_X: pose.r[0] <= wr_data;
        dqpt_pkg::REG_REAL_Y: pose.r[1] <= wr_data;
        dqpt_pkg::REG_REAL_Z: pose.r[2] <= wr_data;
        dqpt_pkg::REG_REAL_W: pose.r[3] <= wr_data;
        dqpt_pkg::REG_DUAL_X: pose.d[0] <= wr_data;
        dqpt_pkg::REG_DUAL_Y: pose.d[1] <= wr_data;
        dqpt_pkg::REG_DUAL_Z: pose.d[2] <= wr_data;
        dqpt_pkg::REG_DUAL_W: pose.d[3] <= wr_data;
      endcase
    end
  end

endmodule

// ===== hdl/dqpt_dual_pipe.sv =====
module dqpt_dual_pipe #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                 clk,
  input  dqpt_pkg::pose_t                      pose,
  output logic [2:0][2*dqpt_pkg::DATA_W-1:0]   dual2
);

  localparam int DW = dqpt_pkg::DATA_W;
  localparam int PW = 2 * DW;

  logic signed [DW-1:0] r [4];
  logic signed [DW-1:0] d [4];

  // stage 1 products, stage 2 partial sums, stage 3 doubled dual vector
  logic signed [PW-1:0] qa [3];
  logic signed [PW-1:0] qb [3];
  logic signed [PW-1:0] qr [3];
  logic signed [PW-1:0] qd [3];
  logic signed [PW-1:0] sum [3];
  logic signed [PW-1:0] rimg [3];
  logic signed [PW-1:0] d2 [3];

  for (genvar g = 0; g < 4; g++) begin : g_unpack
    assign r[g] = $signed(pose.r[g]);
    assign d[g] = $signed(pose.d[g]);
  end

  // the user keeps pose static while items are in flight (unenforced),
  // so it runs freely, with latency below the point path's use of it
  for (genvar i = 0; i < 3; i++) begin : g_lane
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;

    always_ff @(posedge clk) begin
      qa[i] <= r[J] * d[K];
      qb[i] <= r[K] * d[J];
      qr[i] <= r[i] * d[dqpt_pkg::W_IDX];
      qd[i] <= d[i] * r[dqpt_pkg::W_IDX];
    end

    // 32x32 floored products never reach the 64-bit limits here
    always_ff @(posedge clk) begin
      sum[i]  <= (qd[i] >>> FRAC_BITS) + (qa[i] >>> FRAC_BITS) - (qb[i] >>> FRAC_BITS);
      rimg[i] <= qr[i] >>> FRAC_BITS;
    end

    always_ff @(posedge clk) begin
      d2[i] <= (rimg[i] - sum[i]) <<< 1;
    end

    assign dual2[i] = d2[i];
  end

endmodule

// ===== hdl/dqpt_point_pipe.sv =====
module dqpt_point_pipe #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  dqpt_pkg::pose_t                      pose,
  input  logic [2:0][2*dqpt_pkg::DATA_W-1:0]   dual2,
  input  logic                                 in_valid,
  input  logic                                 in_rot,
  input  logic signed [dqpt_pkg::DATA_W-1:0]   in_x,
  input  logic signed [dqpt_pkg::DATA_W-1:0]   in_y,
  input  logic signed [dqpt_pkg::DATA_W-1:0]   in_z,
  output logic                                 out_valid,
  output logic signed [dqpt_pkg::DATA_W-1:0]   out_x,
  output logic signed [dqpt_pkg::DATA_W-1:0]   out_y,
  output logic signed [dqpt_pkg::DATA_W-1:0]   out_z
);

  localparam int DW   = dqpt_pkg::DATA_W;
  localparam int PW   = 2 * DW;
  localparam int EW   = PW + 1;
  localparam int TW   = PW + 1 - FRAC_BITS;  // r x v + v*w never needs more
  localparam int LW   = 2 * DW + 1;
  localparam int SW   = DW + TW;
  localparam int NSTG = 7;

  localparam logic signed [PW-1:0] MAX64 = {1'b0, {(PW-1){1'b1}}};
  localparam logic signed [PW-1:0] MIN64 = {1'b1, {(PW-1){1'b0}}};
  localparam logic signed [DW-1:0] MAX32 = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] MIN32 = {1'b1, {(DW-1){1'b0}}};

  function automatic logic signed [PW-1:0] add_sat(input logic signed [PW-1:0] a,
                                                    input logic signed [PW-1:0] b);
    logic signed [EW-1:0] s;
    s = EW'(a) + EW'(b);
    if (s[PW] != s[PW-1]) return s[PW] ? MIN64 : MAX64;
    return s[PW-1:0];
  endfunction

  function automatic logic signed [PW-1:0] sub_sat(input logic signed [PW-1:0] a,
                                                    input logic signed [PW-1:0] b);
    logic signed [EW-1:0] s;
    s = EW'(a) - EW'(b);
    if (s[PW] != s[PW-1]) return s[PW] ? MIN64 : MAX64;
    return s[PW-1:0];
  endfunction

  function automatic logic signed [PW-1:0] dbl_sat(input logic signed [PW-1:0] a);
    if (a[PW-1] != a[PW-2]) return a[PW-1] ? MIN64 : MAX64;
    return a <<< 1;
  endfunction

  // recombine split product, floor, clamp to 64 bits
  function automatic logic signed [PW-1:0] fold_sat(input logic signed [TW-1:0] hi,
                                                     input logic signed [LW-1:0] lo);
    logic signed [SW-1:0] full;
    logic signed [SW-1:0] sh;
    full = (SW'(hi) <<< DW) + SW'(lo);
    sh   = full >>> FRAC_BITS;
    if (sh[SW-1:PW-1] == '0 || sh[SW-1:PW-1] == '1) return sh[PW-1:0];
    return sh[SW-1] ? MIN64 : MAX64;
  endfunction

  function automatic logic signed [DW-1:0] sat32(input logic signed [PW-1:0] a);
    if (a[PW-1:DW-1] == '0 || a[PW-1:DW-1] == '1) return a[DW-1:0];
    return a[PW-1] ? MIN32 : MAX32;
  endfunction

  logic signed [DW-1:0] r [4];

  logic                 vld [NSTG];
  logic                 rot [NSTG];
  logic signed [DW-1:0] v   [NSTG][3];

  logic signed [PW-1:0] pa [3];
  logic signed [PW-1:0] pb [3];
  logic signed [PW-1:0] pw [3];
  logic signed [TW-1:0] tmp [3];
  logic signed [LW-1:0] ma_lo [3];
  logic signed [TW-1:0] ma_hi [3];
  logic signed [LW-1:0] mb_lo [3];
  logic signed [TW-1:0] mb_hi [3];
  logic signed [PW-1:0] fa [3];
  logic signed [PW-1:0] fb [3];
  logic signed [PW-1:0] real_v [3];
  logic signed [PW-1:0] tsum [3];
  logic signed [DW-1:0] res [3];
  logic                 res_vld;

  for (genvar g = 0; g < 4; g++) begin : g_unpack
    assign r[g] = $signed(pose.r[g]);
  end

  // item control and point travel alongside the arithmetic
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NSTG; s++) vld[s] <= 1'b0;
      res_vld <= 1'b0;
    end else begin
      vld[0] <= in_valid;
      for (int s = 1; s < NSTG; s++) vld[s] <= vld[s-1];
      res_vld <= vld[NSTG-1];
    end
  end

  always_ff @(posedge clk) begin
    rot[0]  <= in_rot;
    v[0][0] <= in_x;
    v[0][1] <= in_y;
    v[0][2] <= in_z;
    for (int s = 1; s < NSTG; s++) begin
      rot[s] <= rot[s-1];
      v[s]   <= v[s-1];
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;

    // stage 1: r x v and v*w products
    always_ff @(posedge clk) begin
      pa[i] <= r[J] * v[0][K];
      pb[i] <= r[K] * v[0][J];
      pw[i] <= v[0][i] * r[dqpt_pkg::W_IDX];
    end

    // stage 2: rvc + v*w, exact in TW bits
    always_ff @(posedge clk) begin
      tmp[i] <= TW'((pa[i] >>> FRAC_BITS) - (pb[i] >>> FRAC_BITS) + (pw[i] >>> FRAC_BITS));
    end

    // stage 3: r x tmp, operand split at 32 bits into two partial products
    always_ff @(posedge clk) begin
      ma_lo[i] <= r[J] * $signed({1'b0, tmp[K][DW-1:0]});
      ma_hi[i] <= r[J] * $signed(tmp[K][TW-1:DW]);
      mb_lo[i] <= r[K] * $signed({1'b0, tmp[J][DW-1:0]});
      mb_hi[i] <= r[K] * $signed(tmp[J][TW-1:DW]);
    end

    // stage 4: these can hit the 64-bit limits
    always_ff @(posedge clk) begin
      fa[i] <= fold_sat(ma_hi[i], ma_lo[i]);
      fb[i] <= fold_sat(mb_hi[i], mb_lo[i]);
    end

    always_ff @(posedge clk) begin
      real_v[i] <= sub_sat(fa[i], fb[i]);
    end

    always_ff @(posedge clk) begin
      tsum[i] <= rot[5] ? dbl_sat(real_v[i])
                        : add_sat(dbl_sat(real_v[i]), $signed(dual2[i]));
    end

    always_ff @(posedge clk) begin
      res[i] <= sat32(add_sat(PW'(v[NSTG-1][i]), tsum[i]));
    end
  end

  assign out_valid = res_vld;
  assign out_x     = res[0];
  assign out_y     = res[1];
  assign out_z     = res[2];

endmodule

// ===== hdl/dual_quaternion_point_transform.sv =====
// Pipeline: input register, six arithmetic stages, result register; done
//   rises with the registered result of each accepted item.
// Throughput: one item per clock unless busy; no multiplier is shared (33 in all).
// Reset (rst, synchronous): flushes all items in flight and loads the identity pose.
// busy is high only during reset; results leave on done and are never held.
module dual_quaternion_point_transform #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                command,
  input  logic signed [dqpt_pkg::DATA_W-1:0]  coord_x,
  input  logic signed [dqpt_pkg::DATA_W-1:0]  coord_y,
  input  logic signed [dqpt_pkg::DATA_W-1:0]  coord_z,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dqpt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dqpt_pkg::DATA_W-1:0]         cfg_data,
  output logic                                done,
  output logic signed [dqpt_pkg::DATA_W-1:0]  out_x,
  output logic signed [dqpt_pkg::DATA_W-1:0]  out_y,
  output logic signed [dqpt_pkg::DATA_W-1:0]  out_z
);

  localparam int PW = 2 * dqpt_pkg::DATA_W;

  dqpt_pkg::pose_t     pose;
  logic [2:0][PW-1:0]  dual2;
  logic                accept;

  assign busy      = rst;
  assign cfg_ready = !rst;
  assign accept    = start && !busy;

  dqpt_cfg_regs #(
    .FRAC_BITS (FRAC_BITS)
  ) u_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .pose     (pose)
  );

  dqpt_dual_pipe #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dual (
    .clk   (clk),
    .pose  (pose),
    .dual2 (dual2)
  );

  dqpt_point_pipe #(
    .FRAC_BITS (FRAC_BITS)
  ) u_point (
    .clk       (clk),
    .rst       (rst),
    .pose      (pose),
    .dual2     (dual2),
    .in_valid  (accept),
    .in_rot    (command),
    .in_x      (coord_x),
    .in_y      (coord_y),
    .in_z      (coord_z),
    .out_valid (done),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z)
  );

endmodule

// ===== hdl/dqpt_checker.sv =====
module dqpt_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                start,
  input logic                                busy,
  input logic                                command,
  input logic signed [dqpt_pkg::DATA_W-1:0]  coord_x,
  input logic signed [dqpt_pkg::DATA_W-1:0]  coord_y,
  input logic signed [dqpt_pkg::DATA_W-1:0]  coord_z,
  input logic                                done,
  input logic signed [dqpt_pkg::DATA_W-1:0]  out_x,
  input logic signed [dqpt_pkg::DATA_W-1:0]  out_y,
  input logic signed [dqpt_pkg::DATA_W-1:0]  out_z
);

  // every result traces back to a matching accepted item
  a_done_has_item: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 8))
    else $error("result without a matching item");

  // an item not flushed by reset always comes out
  a_item_not_lost: assert property (@(posedge clk) disable iff (rst)
    ($past(start && !busy, 8) && !$past(rst, 1) && !$past(rst, 2) && !$past(rst, 3) &&
     !$past(rst, 4) && !$past(rst, 5) && !$past(rst, 6) && !$past(rst, 7)) |-> done)
    else $error("item lost");

  // a rotation of the origin is the origin for any pose
  a_origin_fixed: assert property (@(posedge clk) disable iff (rst)
    (done && $past(start && !busy && command && coord_x == 0 && coord_y == 0 &&
                   coord_z == 0, 8))
    |-> (out_x == 0 && out_y == 0 && out_z == 0))
    else $error("origin not preserved by rotation");

  a_flush_on_reset: assert property (@(posedge clk)
    $past(rst) |-> !done)
    else $error("result right after reset");

endmodule

bind dual_quaternion_point_transform dqpt_checker u_dqpt_checker (.*);
